[rtl/qas_pkg.sv]
// Package for the quoted argument splitter: beat types, step bundle and
// character constants. No dependencies.
`default_nettype none

package qas_pkg;

    // Characters with special meaning
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;

    // Input beat
    typedef struct packed {
        logic [7:0] in_char;
        logic       is_end;
    } item_t;

    // Output beat
    typedef struct packed {
        logic [7:0] out_char;
        logic       has_char;
        logic       arg_end;
        logic       last;
    } result_t;

    // Parser flags
    typedef struct packed {
        logic in_single_quote;
        logic in_double_quote;
        logic backslash_pending;
        logic argument_open;
        logic any_argument_closed;
    } flags_t;

    // Results produced by one accepted item
    typedef struct packed {
        logic [1:0] count;
        result_t    res0;
        result_t    res1;
    } step_t;

endpackage

`default_nettype wire

[rtl/qas_step.sv]
// Per-byte splitter step: parser flags, escape config bit and the decode of
// one input beat into zero, one or two result beats. Depends on qas_pkg.
`default_nettype none

module qas_step
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            cfg_we,
    input  wire logic            cfg_wdata,
    input  wire logic            take,
    input  wire qas_pkg::item_t  item,
    output qas_pkg::step_t       step
);

    qas_pkg::flags_t flags_reg;
    qas_pkg::flags_t flags_next;
    logic            esc_reg;

    logic [7:0] c;
    logic       is_ws;
    logic       escapable;
    logic       emit;
    logic [1:0] n;

    assign c         = item.in_char;
    assign is_ws     = (c == qas_pkg::CH_SPACE) ||
                       (c >= qas_pkg::CH_TAB && c <= qas_pkg::CH_CR);
    assign escapable = (c == qas_pkg::CH_DQUOTE) || (c == qas_pkg::CH_SQUOTE) ||
                       (c == qas_pkg::CH_BSLASH && esc_reg);

    // Decode one beat against the current flags
    always_comb
    begin
        flags_next = flags_reg;
        step       = '0;
        emit       = 1'b0;
        n          = 2'd0;
        if (item.is_end)
        begin
            // close whatever is open; a pending backslash goes out literally
            if (flags_reg.backslash_pending || flags_reg.argument_open ||
                !flags_reg.any_argument_closed)
            begin
                step.res0.out_char = flags_reg.backslash_pending ? qas_pkg::CH_BSLASH
                                                                 : 8'h00;
                step.res0.has_char = flags_reg.backslash_pending;
                step.res0.arg_end  = 1'b1;
                n = 2'd1;
            end
            flags_next = '0;
        end
        else if (flags_reg.backslash_pending && escapable)
        begin
            flags_next.backslash_pending = 1'b0;
            step.res0.out_char = c;
            step.res0.has_char = 1'b1;
            n = 2'd1;
        end
        else
        begin
            // literal backslash first, then the byte as usual
            if (flags_reg.backslash_pending)
            begin
                flags_next.backslash_pending = 1'b0;
                step.res0.out_char = qas_pkg::CH_BSLASH;
                step.res0.has_char = 1'b1;
                n = 2'd1;
            end
            if (is_ws && !flags_reg.in_single_quote && !flags_reg.in_double_quote)
            begin
                if (flags_reg.argument_open)
                begin
                    if (n != 2'd0)
                    begin
                        step.res0.arg_end = 1'b1;
                    end
                    else
                    begin
                        step.res0.arg_end = 1'b1;
                        n = 2'd1;
                    end
                    flags_next.argument_open       = 1'b0;
                    flags_next.any_argument_closed = 1'b1;
                end
            end
            else
            begin
                flags_next.argument_open = 1'b1;
                if (c == qas_pkg::CH_BSLASH && !flags_reg.in_single_quote)
                begin
                    flags_next.backslash_pending = 1'b1;
                end
                else if (flags_reg.in_single_quote)
                begin
                    if (c == qas_pkg::CH_SQUOTE)
                        flags_next.in_single_quote = 1'b0;
                    else
                        emit = 1'b1;
                end
                else if (flags_reg.in_double_quote)
                begin
                    if (c == qas_pkg::CH_DQUOTE)
                        flags_next.in_double_quote = 1'b0;
                    else
                        emit = 1'b1;
                end
                else if (c == qas_pkg::CH_SQUOTE)
                begin
                    flags_next.in_single_quote = 1'b1;
                end
                else if (c == qas_pkg::CH_DQUOTE)
                begin
                    flags_next.in_double_quote = 1'b1;
                end
                else
                begin
                    emit = 1'b1;
                end
                if (emit)
                begin
                    if (n == 2'd0)
                    begin
                        step.res0.out_char = c;
                        step.res0.has_char = 1'b1;
                        n = 2'd1;
                    end
                    else
                    begin
                        step.res1.out_char = c;
                        step.res1.has_char = 1'b1;
                        n = 2'd2;
                    end
                end
            end
        end
        // mark the final beat of this item
        if (n == 2'd1)
            step.res0.last = 1'b1;
        if (n == 2'd2)
            step.res1.last = 1'b1;
        step.count = n;
    end

    // Flags and config register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flags_reg <= '0;
            esc_reg   <= 1'b0;
        end
        else
        begin
            if (take)
                flags_reg <= flags_next;
            if (cfg_we)
                esc_reg <= cfg_wdata;
        end
    end

endmodule

`default_nettype wire

[rtl/quoted_argument_splitter.sv]
// A result beat is written into the queue when its input beat is taken and is offered on out from the queue head.
// One input beat per cycle while in_ready is high; an item with two results leaves as
//   two output beats, so the output port sets the sustained rate.
// in_ready is high while the queue (QUEUE_DEPTH beats) has room for two beats.
// Reset (rst_n low, asynchronous): flags, escape bit and queue pointers and count are cleared.
// Top level of the quoted argument splitter. Depends on qas_pkg and qas_step.
`default_nettype none

module quoted_argument_splitter
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_we,
    input  wire logic              cfg_wdata,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire qas_pkg::item_t    in_data,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output qas_pkg::result_t       out_data
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    qas_pkg::step_t   step;
    qas_pkg::result_t queue_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [PTR_W-1:0] wr_ptr_inc;
    logic             take;
    logic             pop;
    logic [1:0]       push_n;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        ptr_inc = (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    // Parser step
    qas_step u_step
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .take      (take),
        .item      (in_data),
        .step      (step)
    );

    // Handshakes
    assign in_ready  = (count_reg <= CNT_W'(QUEUE_DEPTH - 2));
    assign take      = in_valid && in_ready;
    assign out_valid = (count_reg != '0);
    assign pop       = out_valid && out_ready;
    assign out_data  = queue_reg[rd_ptr_reg];
    assign push_n    = take ? step.count : 2'd0;

    // Queue pointers
    assign wr_ptr_inc = ptr_inc(wr_ptr_reg);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        if (push_n == 2'd1)
            wr_ptr_next = wr_ptr_inc;
        else if (push_n == 2'd2)
            wr_ptr_next = ptr_inc(wr_ptr_inc);
        rd_ptr_next = pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg + CNT_W'(push_n) - CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Queue storage
    always_ff @(posedge clk)
    begin
        if (push_n != 2'd0)
            queue_reg[wr_ptr_reg] <= step.res0;
        if (push_n == 2'd2)
            queue_reg[wr_ptr_inc] <= step.res1;
    end

endmodule

`default_nettype wire

[rtl/qas_checker.sv]
// Port-level checks for quoted_argument_splitter and the bind that attaches them.
// Depends on qas_pkg and the top level.
`default_nettype none

module qas_checker
(
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              in_valid,
    input wire logic              in_ready,
    input wire logic              out_valid,
    input wire logic              out_ready,
    input wire qas_pkg::result_t  out_data
);

    // A beat with no byte only ever closes an argument and ends its item
    a_empty_beat: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_data.has_char) |->
            (out_data.arg_end && out_data.last && out_data.out_char == 8'h00))
        else $error("empty beat without arg_end/last or with nonzero char");

    // An empty result queue always takes input
    a_idle_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled while no result pending");

    // With nothing queued and no beat taken, nothing is queued in the next cycle
    a_ready_after_reset: assert property (@(posedge clk) disable iff (!rst_n)
        (!out_valid && !(in_valid && in_ready)) |=> !out_valid)
        else $error("result appeared without an accepted input beat");

    // A stalled output beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
        else $error("output beat changed while stalled");

endmodule

bind quoted_argument_splitter qas_checker u_qas_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);

`default_nettype wire

[test/qas_checker.sv]
// Scoreboard for the quoted argument splitter: watches both beat channels,
// predicts result beats from accepted input beats and compares them in order.
// Depends on qas_pkg.
`timescale 1ns / 1ps

module qas_scoreboard
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic             cfg_wdata,
    input  logic             in_valid,
    input  logic             in_ready,
    input  qas_pkg::item_t   in_data,
    input  logic             out_valid,
    input  logic             out_ready,
    input  qas_pkg::result_t out_data,
    output int               fail_count,
    output int               pending,
    output int               checked
);

    // Predictor state: parser flags and the escape bit
    qas_pkg::flags_t  flg;
    logic             esc_bs;

    // Results still owed by the block, oldest first
    qas_pkg::result_t expected_beats[$];

    // Results of the beat being predicted (two at most)
    qas_pkg::result_t step_res[2];
    int               step_n;

    int      n_fail;
    int      n_checked;

    function automatic bit is_blank(logic [7:0] c);
        return c == qas_pkg::CH_SPACE || (c >= qas_pkg::CH_TAB && c <= qas_pkg::CH_CR);
    endfunction

    function automatic void emit(logic [7:0] c, logic has, logic fin);
        step_res[step_n] = '{out_char: (has ? c : 8'h00), has_char: has,
                             arg_end: fin, last: 1'b0};
        step_n++;
    endfunction

    // One byte with no backslash waiting
    function automatic void take_byte(logic [7:0] c);
        if (is_blank(c) && !flg.in_single_quote && !flg.in_double_quote)
        begin
            // unquoted whitespace closes an open argument, else it is skipped
            if (flg.argument_open)
            begin
                if (step_n > 0)
                    step_res[step_n - 1].arg_end = 1'b1;
                else
                    emit(8'h00, 1'b0, 1'b1);
                flg.argument_open       = 1'b0;
                flg.any_argument_closed = 1'b1;
            end
            return;
        end
        flg.argument_open = 1'b1;
        if (c == qas_pkg::CH_BSLASH && !flg.in_single_quote)
            flg.backslash_pending = 1'b1;
        else if (flg.in_single_quote)
        begin
            if (c == qas_pkg::CH_SQUOTE)
                flg.in_single_quote = 1'b0;
            else
                emit(c, 1'b1, 1'b0);
        end
        else if (flg.in_double_quote)
        begin
            if (c == qas_pkg::CH_DQUOTE)
                flg.in_double_quote = 1'b0;
            else
                emit(c, 1'b1, 1'b0);
        end
        else if (c == qas_pkg::CH_SQUOTE)
            flg.in_single_quote = 1'b1;
        else if (c == qas_pkg::CH_DQUOTE)
            flg.in_double_quote = 1'b1;
        else
            emit(c, 1'b1, 1'b0);
    endfunction

    // Expected results for one accepted input beat
    function automatic void predict_beat(qas_pkg::item_t it);
        logic [7:0] c;
        c      = it.in_char;
        step_n = 0;
        if (it.is_end)
        begin
            // close whatever is open; a blank string still gives one empty argument
            if (flg.backslash_pending || flg.argument_open || !flg.any_argument_closed)
                emit(qas_pkg::CH_BSLASH, flg.backslash_pending, 1'b1);
            flg = '0;
        end
        else if (flg.backslash_pending)
        begin
            flg.backslash_pending = 1'b0;
            if (c == qas_pkg::CH_DQUOTE || c == qas_pkg::CH_SQUOTE ||
                (c == qas_pkg::CH_BSLASH && esc_bs))
                emit(c, 1'b1, 1'b0);
            else
            begin
                emit(qas_pkg::CH_BSLASH, 1'b1, 1'b0);
                take_byte(c);
            end
        end
        else
            take_byte(c);
        if (step_n > 0)
            step_res[step_n - 1].last = 1'b1;
        for (int i = 0; i < step_n; i++)
            expected_beats = {expected_beats, step_res[i]};
    endfunction

    // Predict on input beats, compare on output beats
    always @(posedge clk or negedge rst_n)
    begin
        qas_pkg::result_t want;
        if (!rst_n)
        begin
            flg       = '0;
            esc_bs    = 1'b0;
            n_fail    = 0;
            n_checked = 0;
            expected_beats.delete();
        end
        else
        begin
            // an item taken on the write edge still sees the old escape bit
            if (in_valid && in_ready)
                predict_beat(in_data);
            if (cfg_we)
                esc_bs = cfg_wdata;
            if (out_valid && out_ready)
            begin
                if (expected_beats.size() == 0)
                begin
                    $display("%0t: unexpected result beat %h", $time, out_data);
                    n_fail++;
                end
                else
                begin
                    want = expected_beats.pop_front();
                    n_checked++;
                    if (out_data.out_char !== want.out_char
                        || out_data.has_char !== want.has_char
                        || out_data.arg_end !== want.arg_end
                        || out_data.last !== want.last)
                    begin
                        $display("%0t: result mismatch, expected char %h has %b end %b last %b,",
                                 $time, want.out_char, want.has_char, want.arg_end, want.last);
                        $display("%0t:   got char %h has %b end %b last %b", $time,
                                 out_data.out_char, out_data.has_char, out_data.arg_end,
                                 out_data.last);
                        n_fail++;
                    end
                end
            end
        end
        fail_count <= n_fail;
        checked    <= n_checked;
        pending    <= expected_beats.size();
    end

endmodule

[test/tb_quoted_argument_splitter.sv]
// Top of the quoted argument splitter testbench: clock, reset, stimulus,
// random back-pressure and the verdict. Depends on qas_pkg and qas_scoreboard.
`timescale 1ns / 1ps

module tb_quoted_argument_splitter;

    localparam int PHASE_ITEMS = 335;
    localparam int HOLD_CYCLES = 120;
    localparam int SETTLE      = 8;
    localparam int LIMIT       = 400000;

    logic             clk       = 1'b0;
    logic             rst_n     = 1'b0;
    logic             cfg_we    = 1'b0;
    logic             cfg_wdata = 1'b0;
    logic             in_valid  = 1'b0;
    logic             in_ready;
    qas_pkg::item_t   in_data   = '0;
    logic             out_valid;
    logic             out_ready = 1'b0;
    qas_pkg::result_t out_data;

    int fail_count;
    int pending;
    int checked;
    int cycle_count = 0;
    int items_sent  = 0;
    int strings_sent = 0;
    int cfg_writes  = 0;
    bit send_calm   = 1'b0;

    quoted_argument_splitter u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    qas_scoreboard u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_data    (in_data),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_data   (out_data),
        .fail_count (fail_count),
        .pending    (pending),
        .checked    (checked)
    );

    // 12 ns clock
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending);
            $display("tb: failure");
            $finish;
        end
    end

    // Result side: random stalls, calm stretches and two long hold-offs
    initial
    begin
        int  gap;
        int  beats_taken;
        bit  calm;
        beats_taken = 0;
        calm        = 1'b0;
        wait (rst_n);
        forever
        begin
            if (beats_taken % 40 == 0)
                calm = ($urandom_range(0, 3) == 0);
            if (beats_taken == 300 || beats_taken == 900)
            begin
                // long hold-off so the block fills and stalls its input
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            gap = calm ? 0 : $urandom_range(0, 7);
            if (gap > 0)
            begin
                out_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!(out_valid && out_ready))
                @(posedge clk);
            beats_taken++;
        end
    end

    // Offer one input beat and wait until it is taken
    task automatic send_item(qas_pkg::item_t it);
        int gap;
        if (items_sent % 40 == 0)
            send_calm = ($urandom_range(0, 3) == 0);
        gap = send_calm ? 0 : $urandom_range(0, 7);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        items_sent++;
    endtask

    task automatic send_char(logic [7:0] c);
        send_item('{in_char: c, is_end: 1'b0});
    endtask

    // End of string; the byte field carries junk since it is ignored
    task automatic send_end();
        send_item('{in_char: 8'($urandom_range(0, 255)), is_end: 1'b1});
        strings_sent++;
    endtask

    task automatic send_text(string s);
        for (int i = 0; i < s.len(); i++)
            send_char(s[i]);
        send_end();
    endtask

    // Stop offering and wait until every owed result has come out
    task automatic drain();
        in_valid <= 1'b0;
        // let the count of the last taken beat settle first
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_escape(logic v);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we    <= 1'b0;
        cfg_writes++;
    endtask

    // Bytes weighted toward the ones the parser cares about
    function automatic logic [7:0] pick_char();
        case ($urandom_range(0, 9))
            0:       return qas_pkg::CH_SPACE;
            1:       return 8'($urandom_range(qas_pkg::CH_TAB, qas_pkg::CH_CR));
            2:       return qas_pkg::CH_SQUOTE;
            3:       return qas_pkg::CH_DQUOTE;
            4, 5:    return qas_pkg::CH_BSLASH;
            6:       return 8'($urandom_range(0, 255));
            default: return 8'h61 + 8'($urandom_range(0, 25));
        endcase
    endfunction

    // Random strings, mostly shaped, some pure noise
    task automatic random_phase(int budget);
        int         start;
        int         len;
        bit         noise;
        logic [7:0] c;
        start = items_sent;
        while (items_sent - start < budget)
        begin
            len   = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 2) : $urandom_range(1, 14);
            noise = ($urandom_range(0, 9) == 0);
            for (int i = 0; i < len; i++)
            begin
                c = noise ? 8'($urandom_range(0, 255)) : pick_char();
                send_char(c);
            end
            send_end();
        end
    endtask

    // Main sequence
    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty string
        send_end();
        // blank string, whitespace range ends
        send_char(qas_pkg::CH_SPACE);
        send_char(qas_pkg::CH_TAB);
        send_char(qas_pkg::CH_CR);
        send_end();
        // escaped quote, literal x, backslash left pending at the end
        send_text("\\\"x\\");
        // unescaped backslash pair, backslash before space, open single quote
        send_text("\\\\ 'q");
        // byte extremes and trailing whitespace
        send_char(8'h00);
        send_char(8'hFF);
        send_char(qas_pkg::CH_SPACE);
        send_end();
        // whitespace inside double quotes
        send_text("\" a\"");

        random_phase(PHASE_ITEMS);
        drain();
        write_escape(1'b1);
        random_phase(PHASE_ITEMS);
        drain();
        write_escape(1'b0);
        random_phase(PHASE_ITEMS);
        drain();
        write_escape(1'b1);
        random_phase(PHASE_ITEMS);
        drain();

        $display("run: %0d input beats in %0d strings, %0d escape-bit writes",
                 items_sent, strings_sent, cfg_writes);
        $display("run: %0d result beats compared, %0d errors", checked, fail_count);
        if (fail_count == 0 && pending == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
